// File: rtl/anp_pkg.sv
// Package for the ASCII number parser: character codes, radix and position
// types, digit limits and payload types. No dependencies.
package anp_pkg;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 6;

  typedef logic [CH_W-1:0]         char_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [VAL_W-1:0]        acc_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_ZERO  = 2'd1,
    POS_BODY  = 2'd2
  } pos_t;

  // Character codes.
  localparam char_t CH_NUL     = 8'h00;
  localparam char_t CH_DOLLAR  = 8'h24;
  localparam char_t CH_PERCENT = 8'h25;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_ONE     = 8'h31;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_UA      = 8'h41;
  localparam char_t CH_UB      = 8'h42;
  localparam char_t CH_UF      = 8'h46;
  localparam char_t CH_UX      = 8'h58;
  localparam char_t CH_LA      = 8'h61;
  localparam char_t CH_LB      = 8'h62;
  localparam char_t CH_LF      = 8'h66;
  localparam char_t CH_LX      = 8'h78;

  // Offsets from a character code to its digit value.
  localparam char_t OFS_DIGIT = 8'h30;
  localparam char_t OFS_UPPER = 8'h37;
  localparam char_t OFS_LOWER = 8'h57;

  // Largest number of digits each radix allows.
  localparam count_t DEC_LIMIT = 6'd11;
  localparam count_t HEX_LIMIT = 6'd9;
  localparam count_t BIN_LIMIT = 6'd32;

endpackage

// File: rtl/anp_stream_if.sv
// Valid/ready stream interfaces for the character input and the result output.
// Depends on anp_pkg for the payload types.
interface anp_char_if;
  logic           valid;
  logic           ready;
  anp_pkg::char_t ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface anp_result_if;
  logic            valid;
  logic            ready;
  anp_pkg::value_t value;
  logic            error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

// File: rtl/ascii_number_parser_top.sv
// ASCII number parser top level: input register, combinational parse step, result register.
// Depends on anp_pkg and the stream interfaces in anp_stream_if.sv.
//
//   channel   direction  payload                       meaning
//   chars     in         ch[7:0]                       one character, NUL ends the string
//   results   out        value[31:0] signed, error     parsed number, -1 and error on failure
//
// Each accepted character is held in the input register and then folded into the parser
// state by a single Horner step (shift-and-add by 2, 10 or 16); one character per cycle is
// sustained while no NUL is held back by a full result register.
// Only the NUL character yields a result; it waits in the result register until taken, and
// while it waits the input register still accepts a character, and characters other than
// NUL keep flowing. Synchronous active-high reset returns the parser to the string start.
module ascii_number_parser_top (
  input  logic clk,
  input  logic rst,
  anp_char_if.sink     chars,
  anp_result_if.source results
);
  import anp_pkg::*;

  // Input register.
  logic   in_valid;
  char_t  ch_q;

  // Parser state.
  pos_t   pos, pos_next;
  radix_t mode, mode_next;
  acc_t   acc, acc_next;
  count_t cnt, cnt_next;
  logic   err, err_next;

  // Result register.
  logic   out_valid;
  value_t out_value;
  logic   out_error;

  // Step control.
  logic   is_nul;
  logic   out_free;
  logic   advance;
  logic   do_take;
  radix_t eff_mode;
  acc_t   eff_acc;
  count_t eff_cnt;
  logic   eff_err;

  // Digit decode.
  logic   dig_ok;
  char_t  dig_ofs;
  char_t  dig_raw;
  count_t dig_limit;
  acc_t   scaled;

  assign is_nul   = (ch_q == CH_NUL);
  assign out_free = !out_valid || results.ready;
  // A NUL needs a free result register; any other character always proceeds.
  assign advance  = in_valid && (!is_nul || out_free);

  assign chars.ready   = !in_valid || advance;
  assign results.valid = out_valid;
  assign results.value = out_value;
  assign results.error = out_error;

  // Position handling. A leading '0' that is not followed by a radix letter is the
  // decimal digit zero, so the body resumes with one digit already counted.
  always_comb begin
    pos_next  = pos;
    mode_next = mode;
    eff_mode  = mode;
    eff_acc   = acc;
    eff_cnt   = cnt;
    eff_err   = err;
    do_take   = 1'b0;
    case (pos)
      POS_START: begin
        if (is_nul) begin
          pos_next = POS_START;
        end else if (ch_q == CH_DOLLAR) begin
          mode_next = RADIX_HEX;
          pos_next  = POS_BODY;
        end else if (ch_q == CH_PERCENT) begin
          mode_next = RADIX_BIN;
          pos_next  = POS_BODY;
        end else if (ch_q == CH_ZERO) begin
          pos_next = POS_ZERO;
        end else begin
          mode_next = RADIX_DEC;
          eff_mode  = RADIX_DEC;
          pos_next  = POS_BODY;
          do_take   = 1'b1;
        end
      end
      POS_ZERO: begin
        pos_next = POS_BODY;
        if (ch_q == CH_LX || ch_q == CH_UX) begin
          mode_next = RADIX_HEX;
        end else if (ch_q == CH_LB || ch_q == CH_UB) begin
          mode_next = RADIX_BIN;
        end else begin
          mode_next = RADIX_DEC;
          eff_mode  = RADIX_DEC;
          eff_acc   = '0;
          eff_cnt   = count_t'(1);
          eff_err   = 1'b0;
          do_take   = !is_nul;
        end
      end
      default: begin
        do_take = !is_nul;
      end
    endcase
  end

  // Digit decode and Horner step for the effective radix.
  always_comb begin
    dig_ok  = 1'b0;
    dig_ofs = OFS_DIGIT;
    case (eff_mode)
      RADIX_HEX: begin
        dig_limit = HEX_LIMIT;
        scaled    = {eff_acc[VAL_W-5:0], 4'b0000};
        if (ch_q >= CH_ZERO && ch_q <= CH_NINE) begin
          dig_ok = 1'b1;
        end else if (ch_q >= CH_UA && ch_q <= CH_UF) begin
          dig_ok  = 1'b1;
          dig_ofs = OFS_UPPER;
        end else if (ch_q >= CH_LA && ch_q <= CH_LF) begin
          dig_ok  = 1'b1;
          dig_ofs = OFS_LOWER;
        end
      end
      RADIX_BIN: begin
        dig_limit = BIN_LIMIT;
        scaled    = {eff_acc[VAL_W-2:0], 1'b0};
        dig_ok    = (ch_q == CH_ZERO || ch_q == CH_ONE);
      end
      default: begin
        // Decimal, and the unused radix code.
        dig_limit = DEC_LIMIT;
        scaled    = {eff_acc[VAL_W-4:0], 3'b000} + {eff_acc[VAL_W-2:0], 1'b0};
        dig_ok    = (ch_q >= CH_ZERO && ch_q <= CH_NINE);
      end
    endcase
    dig_raw = ch_q - dig_ofs;
  end

  always_comb begin
    acc_next = eff_acc;
    cnt_next = eff_cnt;
    err_next = eff_err;
    if (do_take && !eff_err) begin
      if (!dig_ok || eff_cnt >= dig_limit) begin
        err_next = 1'b1;
      end else begin
        acc_next = scaled + acc_t'(dig_raw[3:0]);
        cnt_next = eff_cnt + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      ch_q <= chars.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_START;
      mode <= RADIX_DEC;
      acc  <= '0;
      cnt  <= '0;
      err  <= 1'b0;
    end else if (advance) begin
      if (is_nul) begin
        pos  <= POS_START;
        mode <= RADIX_DEC;
        acc  <= '0;
        cnt  <= '0;
        err  <= 1'b0;
      end else begin
        pos  <= pos_next;
        mode <= mode_next;
        acc  <= acc_next;
        cnt  <= cnt_next;
        err  <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_nul) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // On the terminator the value is taken after the position step, so a lone "0" reads zero.
  always_ff @(posedge clk) begin
    if (advance && is_nul) begin
      out_value <= eff_err ? value_t'(-1) : value_t'(eff_acc);
      out_error <= eff_err;
    end
  end

  // An error result always carries minus one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_value == value_t'(-1))
    else $error("error result without value -1");

  // A character held back in the input register stays put.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(ch_q))
    else $error("held character lost or changed");

  // Errors arise only in the digit body.
  assert property (@(posedge clk) disable iff (rst)
    err |-> pos == POS_BODY)
    else $error("error flag outside the digit body");

  // The digit count never passes the largest radix limit.
  assert property (@(posedge clk) disable iff (rst)
    cnt <= BIN_LIMIT)
    else $error("digit count beyond limit");

endmodule

// File: dv/ascii_number_parser_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ascii_number_parser_top: drives character strings, predicts results.
// Depends on anp_pkg, the stream interfaces in anp_stream_if.sv and the parser top level.
module ascii_number_parser_top_tb;
  import anp_pkg::*;

  // Parsed number as the result channel carries it.
  typedef struct {
    value_t value;
    logic   error;
  } number_t;

  // Answer typed into the directed table; when typed is clear the predictor decides.
  typedef struct {
    bit      typed;
    number_t num;
  } answer_t;

  // One directed string; the NUL terminator is appended by the driver.
  typedef struct {
    string  text;
    bit     typed;
    value_t value;
    logic   error;
  } vector_t;

  localparam int N_DIRECTED  = 27;
  localparam int ITEMS_PHASE = 130;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  // The directed part: bare prefixes, radix extremes, digit limits and every error path.
  vector_t directed_tab [N_DIRECTED] = '{
    '{"",                                    1'b1, 0,          1'b0},
    '{"0",                                   1'b1, 0,          1'b0},
    '{"0x",                                  1'b1, 0,          1'b0},
    '{"$",                                   1'b1, 0,          1'b0},
    '{"0B",                                  1'b1, 0,          1'b0},
    '{"%",                                   1'b1, 0,          1'b0},
    '{"0X7f",                                1'b0, 0,          1'b0},
    '{"2147483647",                          1'b1, 2147483647, 1'b0},
    '{"4294967295",                          1'b1, -1,         1'b0},
    '{"99999999999",                         1'b0, 0,          1'b0},
    '{"123456789012",                        1'b1, -1,         1'b1},
    '{"0xFFFFFFFF",                          1'b1, -1,         1'b0},
    '{"$DeadBeef",                           1'b0, 0,          1'b0},
    '{"0x123456789",                         1'b0, 0,          1'b0},
    '{"$1234567890",                         1'b1, -1,         1'b1},
    '{"%11111111111111111111111111111111",   1'b1, -1,         1'b0},
    '{"0b000000000000000000000000000000000", 1'b1, -1,         1'b1},
    '{"0b1010",                              1'b1, 10,         1'b0},
    '{"%102",                                1'b1, -1,         1'b1},
    '{"00012",                               1'b0, 0,          1'b0},
    '{"09",                                  1'b1, 9,          1'b0},
    '{"-5",                                  1'b1, -1,         1'b1},
    '{" 7",                                  1'b1, -1,         1'b1},
    '{"0xg",                                 1'b1, -1,         1'b1},
    '{"\377",                                1'b1, -1,         1'b1},
    '{"1x2\200",                             1'b1, -1,         1'b1},
    '{"0y",                                  1'b1, -1,         1'b1}
  };

  logic clk;
  logic rst;

  anp_char_if   chars_if ();
  anp_result_if results_if ();

  ascii_number_parser_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  // Parser state as the predictor keeps it.
  pos_t   parse_pos;
  char_t  lead_char;
  radix_t parse_radix;
  acc_t   parse_acc;
  count_t parse_digits;
  logic   parse_err;

  number_t pending_numbers [$];
  answer_t typed_answers [$];

  int src_idle_pct;
  int dst_stall_pct;
  int failures;
  int cycle_count;
  int chars_sent;
  int strings_sent;
  int numbers_checked;
  int error_numbers;

  // Clock and the single reset pulse at the start of the run.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // The watchdog fails the run once the cycle count passes CYCLE_LIMIT.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("ascii_number_parser_top test failed");
        $finish;
      end
    end
  end

  // The receiver stalls at random at the rate the current phase asks for.
  always @(posedge clk) begin
    results_if.ready <= (dst_stall_pct == 0) || ($urandom_range(99) >= dst_stall_pct);
  end

  function automatic void clear_parse();
    parse_pos    = POS_START;
    lead_char    = CH_NUL;
    parse_radix  = RADIX_DEC;
    parse_acc    = '0;
    parse_digits = '0;
    parse_err    = 1'b0;
  endfunction

  // One Horner step in the current radix. Once an error is flagged the rest of the string
  // is ignored; a digit beyond the radix limit flags an error just like a bad character.
  function automatic void fold_digit(char_t c);
    acc_t   digit;
    acc_t   mult;
    count_t limit;
    bit     ok;
    if (parse_err) return;
    digit = '0;
    ok    = 1'b0;
    case (parse_radix)
      RADIX_HEX: begin
        limit = HEX_LIMIT;
        mult  = 16;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          digit = acc_t'(c - OFS_DIGIT);
          ok    = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
          digit = acc_t'(c - OFS_UPPER);
          ok    = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
          digit = acc_t'(c - OFS_LOWER);
          ok    = 1'b1;
        end
      end
      RADIX_BIN: begin
        limit = BIN_LIMIT;
        mult  = 2;
        // Only '0' and '1' are binary digits; anything else is flagged.
        if (c == CH_ZERO || c == CH_ONE) begin
          digit = acc_t'(c - OFS_DIGIT);
          ok    = 1'b1;
        end
      end
      default: begin
        limit = DEC_LIMIT;
        mult  = 10;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          digit = acc_t'(c - OFS_DIGIT);
          ok    = 1'b1;
        end
      end
    endcase
    if (!ok || parse_digits >= limit) begin
      parse_err = 1'b1;
      return;
    end
    parse_acc    = parse_acc * mult + digit;
    parse_digits = parse_digits + 1'b1;
  endfunction

  // The terminator closes the string: -1 with the error bit, or the accumulated value.
  function automatic bit close_string(output number_t num);
    num.value = parse_err ? value_t'(-1) : value_t'(parse_acc);
    num.error = parse_err;
    clear_parse();
    return 1'b1;
  endfunction

  // Advances the predicted state by one character; returns 1 when a number is due.
  function automatic bit parse_char(input char_t c, output number_t num);
    num = '{value: '0, error: 1'b0};
    case (parse_pos)
      POS_START: begin
        if (c == CH_NUL) return close_string(num);
        lead_char = c;
        if (c == CH_DOLLAR) begin
          parse_radix = RADIX_HEX;
          parse_pos   = POS_BODY;
        end else if (c == CH_PERCENT) begin
          parse_radix = RADIX_BIN;
          parse_pos   = POS_BODY;
        end else if (c == CH_ZERO) begin
          // A leading zero may still turn out to be a prefix.
          parse_pos = POS_ZERO;
        end else begin
          parse_radix = RADIX_DEC;
          parse_pos   = POS_BODY;
          fold_digit(c);
        end
      end
      POS_ZERO: begin
        parse_pos = POS_BODY;
        if (c == CH_LX || c == CH_UX) begin
          parse_radix = RADIX_HEX;
        end else if (c == CH_LB || c == CH_UB) begin
          parse_radix = RADIX_BIN;
        end else begin
          // Not a prefix after all: the zero was a decimal digit.
          parse_radix = RADIX_DEC;
          fold_digit(lead_char);
          if (c == CH_NUL) return close_string(num);
          fold_digit(c);
        end
      end
      default: begin
        if (c == CH_NUL) return close_string(num);
        fold_digit(c);
      end
    endcase
    return 1'b0;
  endfunction

  // Prediction comes first so that a number is queued before it could be compared.
  // Each accepted request on the character channel advances the predictor, and each
  // accepted result is compared against the oldest queued number.
  always @(posedge clk) begin : scoreboard
    number_t want;
    answer_t key;
    if (rst) begin
      clear_parse();
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        if (parse_char(chars_if.ch, want)) begin
          // A directed row with a typed answer overrides the predicted number.
          if (typed_answers.size() != 0) begin
            key = typed_answers.pop_front();
            if (key.typed) want = key.num;
          end
          pending_numbers.push_back(want);
        end
      end
      if (results_if.valid && results_if.ready) begin
        if (pending_numbers.size() == 0) begin
          $error("unexpected result: value %0d error %0b", results_if.value, results_if.error);
          failures++;
        end else begin
          want = pending_numbers.pop_front();
          numbers_checked++;
          if (want.error) error_numbers++;
          if (results_if.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d", want.value, results_if.value);
            failures++;
          end
          if (results_if.error !== want.error) begin
            $error("error mismatch: expected %0b, actual %0b", want.error, results_if.error);
            failures++;
          end
        end
      end
    end
  end

  // Offers one character, with an optional idle stretch first, and returns once it is taken.
  // Valid stays high between back-to-back requests so it is never dropped and raised in one step.
  task automatic send_char(char_t c);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      chars_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    do @(posedge clk); while (!chars_if.ready);
    chars_sent++;
  endtask

  task automatic send_string(char_t text[$], answer_t key);
    typed_answers.push_back(key);
    foreach (text[i]) send_char(text[i]);
    send_char(CH_NUL);
    strings_sent++;
  endtask

  // Builds one random string without its terminator. Most strings are well formed with a
  // random radix prefix and digit count around the limit; some carry a stray character,
  // a few are plain noise or empty. Returns the number of characters built.
  function automatic int build_string(ref char_t text[$]);
    int     pick;
    int     ndig;
    int     limit;
    int     v;
    int     at;
    radix_t radix;
    text.delete();
    pick = $urandom_range(99);
    if (pick < 6) return 0;
    if (pick < 14) begin
      ndig = $urandom_range(1, 6);
      repeat (ndig) text.push_back(char_t'($urandom_range(1, 255)));
      return ndig;
    end
    case ($urandom_range(2))
      0: begin
        radix = RADIX_HEX;
        limit = HEX_LIMIT;
        case ($urandom_range(2))
          0: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_LX);
          end
          1: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_UX);
          end
          default: text.push_back(CH_DOLLAR);
        endcase
      end
      1: begin
        radix = RADIX_BIN;
        limit = BIN_LIMIT;
        case ($urandom_range(2))
          0: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_LB);
          end
          1: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_UB);
          end
          default: text.push_back(CH_PERCENT);
        endcase
      end
      default: begin
        radix = RADIX_DEC;
        limit = DEC_LIMIT;
      end
    endcase
    // Bias the digit count toward the limit and just past it.
    pick = $urandom_range(9);
    if (pick == 0) ndig = limit + $urandom_range(1, 3);
    else if (pick <= 2) ndig = limit;
    else ndig = $urandom_range(0, limit);
    repeat (ndig) begin
      case (radix)
        RADIX_HEX: begin
          v = $urandom_range(15);
          if (v < 10) text.push_back(char_t'(CH_ZERO + v));
          else text.push_back(char_t'(($urandom_range(1) ? CH_UA : CH_LA) + v - 10));
        end
        RADIX_BIN: text.push_back(char_t'(CH_ZERO + $urandom_range(1)));
        default:   text.push_back(char_t'(CH_ZERO + $urandom_range(9)));
      endcase
    end
    if ($urandom_range(99) < 15) begin
      at = $urandom_range(0, text.size());
      text.insert(at, char_t'($urandom_range(1, 255)));
    end
    return text.size();
  endfunction

  initial begin : stimulus
    char_t   text [$];
    answer_t key;
    int      phase_items;
    int      live;

    chars_if.valid   <= 1'b0;
    chars_if.ch      <= CH_NUL;
    src_idle_pct    = 0;
    dst_stall_pct   = 0;
    failures        = 0;
    chars_sent      = 0;
    strings_sent    = 0;
    numbers_checked = 0;
    error_numbers   = 0;
    clear_parse();

    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed table, run without idling so the first string lands right after reset.
    foreach (directed_tab[i]) begin
      text.delete();
      for (int j = 0; j < directed_tab[i].text.len(); j++) begin
        text.push_back(char_t'(directed_tab[i].text[j]));
      end
      key.typed     = directed_tab[i].typed;
      key.num.value = directed_tab[i].value;
      key.num.error = directed_tab[i].error;
      send_string(text, key);
    end

    // Random strings in four phases: no idling, sender gaps, receiver stalls, then both.
    key.typed = 1'b0;
    key.num   = '{value: '0, error: 1'b0};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 0;
          dst_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 59;
          dst_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          dst_stall_pct = 59;
        end
        default: begin
          src_idle_pct  = 22;
          dst_stall_pct = 22;
        end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PHASE) begin
        live = build_string(text);
        send_string(text, key);
        phase_items += live + 1;
      end
    end
    chars_if.valid <= 1'b0;

    // Drain: every queued number must come back, and stray results are caught before the end.
    while (pending_numbers.size() != 0 || typed_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d strings (%0d characters) across four idle and stall mixes.",
             strings_sent, chars_sent);
    $display("Checked %0d numbers, %0d of them flagged as parse errors.",
             numbers_checked, error_numbers);
    if (failures == 0) begin
      $display("ascii_number_parser_top test passed");
    end else begin
      $display("ascii_number_parser_top test failed");
    end
    $finish;
  end

endmodule
